>>> sv/lkvc_pkg.sv
// Shared types and constants of the key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;
    localparam int CAPACITY   = 16;
    localparam int KEY_BITS   = 64;
    localparam int VALUE_BITS = 64;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int CAP_BITS   = 5;
    localparam int UCNT_BITS  = 16;

    localparam logic [1:0] OP_GET   = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic CFG_CAPACITY = 1'b0;
    localparam logic CFG_LOG      = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WAIT, S_DECIDE, S_UPDATE, S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, clear scan results
        logic scan_rd;   // issue read of entry r_ridx
        logic scan_chk;  // compare data read last cycle
        logic upd;       // apply the request to the store
        logic out_load;  // load result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_rd;   // read of final entry issued
    } t_stat;
endpackage

>>> sv/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
// Usage:
//  Slave stream carries one request: tdata = {value, key}, tuser = opcode
//  (0 get, 1 set, 2 clear update counter). Master stream returns one
//  result per request in tdata.
//  Configuration: i_cfg_we with i_cfg_idx 0 (active capacity, 5 bits) or
//  1 (logging enable); write only while idle.
//  Timing: a request is taken in the idle state, the key and value RAMs are
//  scanned one entry per cycle through their registered read port, then a
//  wait state checks the last entry read, a decide state loads the result
//  register and an update state applies the request to the store and
//  ranks. The result is then offered in the output state; no new request
//  is taken before the previous result has been accepted.
//  When the receiver stalls, the result is held and no new request is taken.
//  Reset clears valid bits, ranks, occupancy, counter and logging, sets the
//  capacity to 16; RAM contents stay undefined and unused while invalid.
module lru_key_value_cache_top import lkvc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // key[63:0], value[127:64]
    input  logic [1:0]    s_axis_tuser,   // opcode[1:0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // hit[0], read_value[64:1], evicted[65], evicted_key[129:66],
    // update_count[145:130], zero fill to 151
    output logic [151:0]  m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [4:0]    i_cfg_data
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic                  w_hit, w_ev;
    logic [VALUE_BITS-1:0] w_rv;
    logic [KEY_BITS-1:0]   w_ek;
    logic [UCNT_BITS-1:0]  w_uc;

    lkvc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd));

    lkvc_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_opcode(s_axis_tuser), .i_key(s_axis_tdata[63:0]),
        .i_value(s_axis_tdata[127:64]),
        .o_hit(w_hit), .o_read_value(w_rv), .o_evicted(w_ev),
        .o_evicted_key(w_ek), .o_update_count(w_uc));

    assign m_axis_tdata = {6'd0, w_uc, w_ek, w_ev, w_rv, w_hit};
endmodule

>>> sv/lkvc_ram.sv
// Generic simple dual-port RAM (one write, one read port) with registered read.
`timescale 1ns / 1ps
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/lkvc_ctrl.sv
// Sequencer of the cache: scan, decide, update, deliver.
`timescale 1ns / 1ps
module lkvc_ctrl import lkvc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_SCAN;
            S_SCAN:   if (i_stat.last_rd) n_state = S_WAIT;
            S_WAIT:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_UPDATE;
            S_UPDATE: n_state = S_OUT;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan_rd  = 1'b1;
                o_cmd.scan_chk = 1'b1;
            end
            S_WAIT:   o_cmd.scan_chk = 1'b1;
            S_DECIDE: o_cmd.out_load = 1'b1;
            S_UPDATE: o_cmd.upd = 1'b1;
            S_OUT:    o_out_valid = 1'b1;
            default:  o_cmd = '0;
        endcase
    end
endmodule

>>> sv/lkvc_dp.sv
// Datapath of the cache: stores, scan comparators, ranks and result.
`timescale 1ns / 1ps
module lkvc_dp import lkvc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CAP_BITS-1:0]   i_cfg_data,
    input  logic [1:0]            i_opcode,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic                  o_evicted,
    output logic [KEY_BITS-1:0]   o_evicted_key,
    output logic [UCNT_BITS-1:0]  o_update_count
);
    logic [CAP_BITS-1:0]   r_cap;
    logic                  r_log;
    logic [1:0]            r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [CAPACITY-1:0]   r_valid;
    logic [IDX_BITS-1:0]   r_rank [CAPACITY];
    logic [CNT_BITS-1:0]   r_occ;
    logic [UCNT_BITS-1:0]  r_ucnt;
    logic [IDX_BITS-1:0]   r_ridx;   // read address
    logic [IDX_BITS-1:0]   r_cidx;   // entry whose data is on the RAM output
    logic                  r_cvld;
    logic                  r_found;
    logic [IDX_BITS-1:0]   r_hidx;
    logic                  r_lfound;
    logic [IDX_BITS-1:0]   r_lidx;
    logic [IDX_BITS-1:0]   r_lrank;
    logic                  r_ffound;
    logic [IDX_BITS-1:0]   r_fidx;
    logic [VALUE_BITS-1:0] r_hval;
    logic [KEY_BITS-1:0]   r_lkey;
    logic                  r_ins;
    logic [IDX_BITS-1:0]   r_slot;
    logic [IDX_BITS-1:0]   r_limit;

    logic [KEY_BITS-1:0]   w_rkey;
    logic [VALUE_BITS-1:0] w_rval;
    logic [IDX_BITS-1:0]   w_raddr;
    logic                  w_kwe, w_vwe;
    logic [CNT_BITS-1:0]   w_ecap;
    logic                  w_full;

    assign w_raddr = r_ridx;
    assign w_kwe   = i_cmd.upd && r_ins;
    assign w_vwe   = i_cmd.upd && (r_ins || (r_found && r_op == OP_SET));

    lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_keys (
        .i_clk(i_clk), .i_we(w_kwe), .i_waddr(r_slot), .i_wdata(r_key),
        .i_raddr(w_raddr), .o_rdata(w_rkey));
    lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(r_slot), .i_wdata(r_val),
        .i_raddr(w_raddr), .o_rdata(w_rval));

    assign o_stat.last_rd = (r_ridx == IDX_BITS'(CAPACITY - 1));

    always_comb begin
        if (r_cap == '0) begin
            w_ecap = CNT_BITS'(1);
        end else if (32'(r_cap) > CAPACITY) begin
            w_ecap = CNT_BITS'(CAPACITY);
        end else begin
            w_ecap = CNT_BITS'(r_cap);
        end
        w_full = (r_occ >= w_ecap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_BITS'(16);
            r_log   <= 1'b0;
            r_valid <= '0;
            r_occ   <= '0;
            r_ucnt  <= '0;
            r_cvld  <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) r_rank[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_CAPACITY) r_cap <= i_cfg_data;
                else r_log <= i_cfg_data[0];
            end
            r_cvld <= i_cmd.scan_rd;
            if (i_cmd.upd) begin
                if (r_op == OP_CLEAR) r_ucnt <= '0;
                if (r_ins) begin
                    r_valid[r_slot] <= 1'b1;
                    if (!w_full) r_occ <= r_occ + 1'b1;
                    if (r_log && r_ucnt != '1) r_ucnt <= r_ucnt + 1'b1;
                end
                if (r_ins || (r_found && (r_op == OP_GET || r_op == OP_SET))) begin
                    // age entries more recent than the limit (all valid entries on an insert), promote the slot
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (IDX_BITS'(i) == r_slot) r_rank[i] <= '0;
                        else if (r_valid[i] && (r_ins || r_rank[i] < r_limit))
                            r_rank[i] <= r_rank[i] + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_key    <= i_key;
            r_val    <= i_value;
            r_ridx   <= '0;
            r_found  <= 1'b0;
            r_lfound <= 1'b0;
            r_ffound <= 1'b0;
        end
        if (i_cmd.scan_rd) begin
            r_cidx <= r_ridx;
            if (!o_stat.last_rd) r_ridx <= r_ridx + 1'b1;
        end
        if (i_cmd.scan_chk && r_cvld) begin
            if (r_valid[r_cidx] && w_rkey == r_key && !r_found) begin
                r_found <= 1'b1;
                r_hidx  <= r_cidx;
                r_hval  <= w_rval;
            end
            if (r_valid[r_cidx] && (!r_lfound || r_rank[r_cidx] > r_lrank)) begin
                r_lfound <= 1'b1;
                r_lidx   <= r_cidx;
                r_lrank  <= r_rank[r_cidx];
                r_lkey   <= w_rkey;
            end
            if (!r_valid[r_cidx] && !r_ffound) begin
                r_ffound <= 1'b1;
                r_fidx   <= r_cidx;
            end
        end
        if (i_cmd.out_load) begin
            r_ins          <= 1'b0;
            o_hit          <= 1'b0;
            o_read_value   <= '0;
            o_evicted      <= 1'b0;
            o_evicted_key  <= '0;
            o_update_count <= r_ucnt;
            if (r_op == OP_CLEAR) o_update_count <= '0;
            if (r_op == OP_GET || r_op == OP_SET) begin
                if (r_found) begin
                    o_hit   <= 1'b1;
                    r_slot  <= r_hidx;
                    r_limit <= r_rank[r_hidx];
                    if (r_op == OP_GET) o_read_value <= r_hval;
                end else if (r_op == OP_SET) begin
                    r_ins <= 1'b1;
                    if (r_log && r_ucnt != '1) o_update_count <= r_ucnt + 1'b1;
                    if (w_full) begin
                        r_slot        <= r_lfound ? r_lidx : '0;
                        o_evicted     <= 1'b1;
                        o_evicted_key <= r_lfound ? r_lkey : '0;
                    end else begin
                        r_slot <= r_ffound ? r_fidx : '0;
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/lru_key_value_cache_top_tb.sv
// Self-checking testbench of the LRU key-value cache top level.
`timescale 1ns / 1ps
module lru_key_value_cache_top_tb import lkvc_pkg::*;;

    localparam int LIMIT_CYCLES = 600000;
    localparam int PHASE_ITEMS  = 200;
    localparam int NUM_PHASES   = 8;
    localparam int KEY_POOL     = 20;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // key[63:0], value[127:64]
    logic [1:0]   s_axis_tuser;   // opcode[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // hit[0], read_value[64:1], evicted[65], evicted_key[129:66],
    // update_count[145:130], zero fill
    logic [151:0] m_axis_tdata;
    logic         i_cfg_we;
    logic         i_cfg_idx;
    logic [4:0]   i_cfg_data;

    lru_key_value_cache_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the cache
    logic [63:0] sh_key [CAPACITY];
    logic [63:0] sh_val [CAPACITY];
    bit          sh_valid [CAPACITY];
    int          sh_rank [CAPACITY];
    int          sh_occ;
    logic [15:0] sh_count;
    logic [4:0]  sh_cap;
    bit          sh_log;

    logic [151:0] result_q [$];
    logic [63:0]  key_pool [KEY_POOL];
    int  idle_mode;   // 0 none, 1 sender, 2 receiver, 3 both
    int  errors;
    int  results_seen;
    int  cycles;
    int  hits_seen;
    int  evicts_seen;

    typedef struct {
        logic [1:0]   op;
        logic [63:0]  key;
        logic [63:0]  val;
        bit           typed;
        logic [151:0] res;
    } t_row;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Make slot s the most recent; entries younger than lim age by one
    function automatic void age_ranks(int s, int lim);
        for (int i = 0; i < CAPACITY; i++)
            if (sh_valid[i] && i != s && sh_rank[i] < lim) sh_rank[i]++;
        sh_rank[s] = 0;
    endfunction

    // Apply one request to the shadow cache and return the packed result
    function automatic logic [151:0] cache_predict(logic [1:0] op, logic [63:0] k,
                                                   logic [63:0] v);
        int s;
        int ecap;
        int worst;
        bit hit;
        bit ev;
        logic [63:0] rd;
        logic [63:0] evk;
        s = -1; hit = 0; ev = 0; rd = '0; evk = '0; worst = 0;
        ecap = (sh_cap < 1) ? 1 : (sh_cap > CAPACITY) ? CAPACITY : int'(sh_cap);
        if (op == OP_GET || op == OP_SET) begin
            for (int i = 0; i < CAPACITY; i++)
                if (s < 0 && sh_valid[i] && sh_key[i] == k) s = i;
            if (s >= 0) begin
                hit = 1;
                if (op == OP_GET) rd = sh_val[s];
                else sh_val[s] = v;
                age_ranks(s, sh_rank[s]);
            end else if (op == OP_SET) begin
                if (sh_occ >= ecap) begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (sh_valid[i] && (s < 0 || sh_rank[i] > worst)) begin
                            s = i;
                            worst = sh_rank[i];
                        end
                    if (s < 0) s = 0;
                    ev = 1;
                    evk = sh_key[s];
                end else begin
                    for (int i = CAPACITY - 1; i >= 0; i--)
                        if (!sh_valid[i]) s = i;
                    if (s < 0) s = 0;
                    sh_occ++;
                end
                sh_valid[s] = 1;
                sh_key[s] = k;
                sh_val[s] = v;
                age_ranks(s, CAPACITY);
                if (sh_log && sh_count != 16'hFFFF) sh_count++;
            end
        end else if (op == OP_CLEAR) begin
            sh_count = '0;
        end
        return {6'b0, sh_count, evk, ev, rd, hit};
    endfunction

    task automatic report_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
            errors++;
        end
    endtask

    // Receiver: random back-pressure in idle modes 2 and 3, checking against the oldest expectation
    always @(posedge i_clk) begin
        logic [151:0] e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    e = result_q.pop_front();
                    report_field("hit", 64'(e[0]), 64'(m_axis_tdata[0]));
                    report_field("read_value", e[64:1], m_axis_tdata[64:1]);
                    report_field("evicted", 64'(e[65]), 64'(m_axis_tdata[65]));
                    report_field("evicted_key", e[129:66], m_axis_tdata[129:66]);
                    report_field("update_count", 64'(e[145:130]),
                                 64'(m_axis_tdata[145:130]));
                    report_field("fill", 64'(e[151:146]), 64'(m_axis_tdata[151:146]));
                    if (m_axis_tdata[0]) hits_seen++;
                    if (m_axis_tdata[65]) evicts_seen++;
                end
            end
            case (idle_mode)
                2: begin
                    m_axis_tready <= ($urandom_range(99) >= 72);
                end
                3: begin
                    m_axis_tready <= ($urandom_range(99) >= 24);
                end
                default: begin
                    m_axis_tready <= 1'b1;
                end
            endcase
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("lru_key_value_cache_top_tb NOT OK");
            $finish;
        end
    end

    // Offer one request; hold it until taken, then record its expectation
    task automatic send_request(logic [1:0] op, logic [63:0] k, logic [63:0] v,
                                bit typed, logic [151:0] res);
        int pct;
        logic [151:0] pred;
        pct = (idle_mode == 1) ? 72 : (idle_mode == 3) ? 24 : 0;
        if ($urandom_range(99) < pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {v, k};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        pred = cache_predict(op, k, v);
        result_q.push_back(typed ? res : pred);
    endtask

    // Stop offering and let every outstanding result arrive
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_CAPACITY) sh_cap = data;
        else sh_log = data[0];
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        t_row dir [$];
        logic [4:0] caps [NUM_PHASES];
        logic [1:0] op;
        logic [63:0] k;
        int r;
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd2, 5'd8};
        errors = 0; results_seen = 0; cycles = 0; hits_seen = 0; evicts_seen = 0;
        idle_mode = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = 1'b0;
        i_cfg_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sh_key[i] = '0; sh_val[i] = '0; sh_valid[i] = 0; sh_rank[i] = 0;
        end
        sh_occ = 0; sh_count = '0; sh_cap = 5'd16; sh_log = 0;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = (i < 4) ? 64'(i) : rand64();
        key_pool[4] = '1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset configuration, extremes, every opcode
        dir.push_back('{OP_GET, 64'd0, 64'd0, 1, 152'd0});
        dir.push_back('{2'd3, '1, '1, 1, 152'd0});
        dir.push_back('{OP_CLEAR, '1, '1, 1, 152'd0});
        dir.push_back('{OP_SET, '1, '1, 1, 152'd0});
        dir.push_back('{OP_GET, '1, 64'd0, 1, {6'b0, 16'd0, 64'd0, 1'b0, {64{1'b1}}, 1'b1}});
        dir.push_back('{OP_SET, 64'd0, 64'd0, 1, 152'd0});
        dir.push_back('{OP_GET, 64'd0, '1, 1, {151'd0, 1'b1}});
        dir.push_back('{OP_SET, '1, 64'h5555_aaaa_0f0f_f0f0, 0, 152'd0});
        dir.push_back('{OP_GET, '1, 64'd0, 0, 152'd0});
        for (int i = 1; i <= 15; i++)
            dir.push_back('{OP_SET, 64'(i * 7), 64'(i), 0, 152'd0});
        dir.push_back('{OP_GET, 64'd14, 64'd0, 0, 152'd0});
        foreach (dir[i])
            send_request(dir[i].op, dir[i].key, dir[i].val, dir[i].typed, dir[i].res);
        drain();

        // Random phases, each under its own configuration and idling pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_CAPACITY, caps[ph]);
            write_reg(CFG_LOG, 5'(ph[0] | (ph == 2)));
            idle_mode = ph % 4;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(99);
                op = (r < 45) ? OP_GET : (r < 90) ? OP_SET : (r < 95) ? OP_CLEAR : 2'd3;
                k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(KEY_POOL - 1)]
                                            : rand64();
                send_request(op, k, rand64(), 0, 152'd0);
                // in phase 3, hold off once mid-phase until the pipe is empty
                if (n == PHASE_ITEMS / 2 && ph == 3) begin
                    s_axis_tvalid <= 1'b0;
                    while (result_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("Covered %0d results (%0d hits, %0d evictions) over %0d settings",
                 results_seen, hits_seen, evicts_seen, NUM_PHASES + 1);
        $display("of capacity and logging, with idle and stall phases on both sides.");
        if (errors == 0 && result_q.size() == 0) begin
            $display("lru_key_value_cache_top_tb OK");
        end else begin
            $display("lru_key_value_cache_top_tb NOT OK");
        end
        $finish;
    end
endmodule
